@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the telnet line parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, off while reset is low.
`define TOR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising clock edge outside reset.
`define TOR_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/tor_pkg.sv @@
// Types and constants of the telnet option refuser and line parser.
// No dependencies; used by tor_front, tor_queue, tor_back and the top level.
package tor_pkg;

  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_WILL = 8'd251;
  localparam logic [7:0] BYTE_WONT = 8'd252;
  localparam logic [7:0] BYTE_DO   = 8'd253;
  localparam logic [7:0] BYTE_DONT = 8'd254;
  localparam logic [7:0] BYTE_LF   = 8'h0a;
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] BYTE_NUL  = 8'h00;

  localparam logic [7:0] MAX_LINE_RESET = 8'd81;
  localparam logic [7:0] MAX_LINE_ZERO  = 8'd255;

  typedef enum logic [2:0] {
    PS_NORMAL = 3'd0,
    PS_IAC    = 3'd1,
    PS_WILL   = 3'd2,
    PS_WONT   = 3'd3,
    PS_DO     = 3'd4,
    PS_DONT   = 3'd5
  } ps_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_REPLY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_CHAR     = 2'd0,
    OP_CHAR_END = 2'd1,
    OP_END      = 2'd2,
    OP_REPLY    = 2'd3
  } op_t;

  // data: character or option byte; aux: line length or reply verb
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] aux;
  } cmd_t;

endpackage

@@ sv/telnet_option_refuser_line_parser.sv @@
// A byte transferred at the input is written into the command queue, and its first
// result then passes through the back end's output register before transfer.
// Throughput: one byte per cycle while the queue is not full; the output side moves
// one result per cycle while out_tready is high. A character ending a line gives
// two results and an option reply four. The command queue (QUEUE_DEPTH entries)
// lets input run ahead of the output. Reset (synchronous, rst_n low) returns to
// normal parse state, clears the line count and queue, sets max_line_length to 81.
`include "assert_macros.svh"

module telnet_option_refuser_line_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // out_byte[7:0], line_length[15:8]
  output logic [1:0]  out_tuser,    // out_kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data   // max_line_length[7:0]
);

  logic          q_full, q_push, q_pop, q_valid;
  tor_pkg::cmd_t q_in_cmd, q_head_cmd;
  logic          out_xfer;
  logic          is_end;
  logic          end_xfer;
  logic          char_split;
  logic          reply_tail;

  tor_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_in_cmd)
  );

  tor_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd)
  );

  tor_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_head_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign out_xfer   = out_tvalid && out_tready;
  assign is_end     = (out_tuser == tor_pkg::KIND_END);
  assign end_xfer   = out_xfer && is_end;
  assign char_split = out_xfer && (out_tuser == tor_pkg::KIND_CHAR) && !out_tlast;
  assign reply_tail = out_xfer && (out_tuser == tor_pkg::KIND_REPLY) && out_tlast;

  `TOR_NEVER(a_end_nonempty, clk, rst_n, end_xfer && (out_tdata[15:8] == 8'd0), "empty line end")
  `TOR_ASSERT(a_char_then_end, clk, rst_n, char_split |=> (out_tvalid && is_end), "no line end")
  `TOR_ASSERT(a_reply_tail, clk, rst_n, reply_tail |-> (out_tdata[7:0] == 8'd0), "bad reply tail")
  `TOR_NEVER(a_push_full, clk, rst_n, q_push && q_full, "command pushed into full queue")

endmodule

@@ sv/tor_front.sv @@
// Front end: accepts received bytes, tracks telnet parse state and line count,
// and pushes one command per byte that causes results. Depends on tor_pkg.
module tor_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,     // rx_byte[7:0]
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          q_full,
  output logic          q_push,
  output tor_pkg::cmd_t q_cmd
);

  tor_pkg::ps_t  ps_r, ps_nxt;
  logic [7:0]    count_r, count_nxt;
  logic [7:0]    max_line_r;
  logic [7:0]    limit;
  logic [7:0]    count_inc;
  logic          in_xfer;

  logic          chr_push;
  tor_pkg::cmd_t chr_cmd;
  logic [7:0]    chr_count;

  logic          push_c;
  tor_pkg::cmd_t cmd_c;

  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;
  assign limit     = (max_line_r == 8'd0) ? tor_pkg::MAX_LINE_ZERO : max_line_r;
  assign count_inc = count_r + 8'd1;

  always_comb begin
    chr_push  = 1'b0;
    chr_cmd   = '{op: tor_pkg::OP_CHAR, data: in_tdata, aux: 8'd0};
    chr_count = count_r;
    if (in_tdata == tor_pkg::BYTE_NUL) begin
      chr_push = 1'b0;
    end else if (in_tdata != tor_pkg::BYTE_LF && in_tdata != tor_pkg::BYTE_CR) begin
      chr_push = 1'b1;
      if (count_inc >= limit) begin
        chr_cmd   = '{op: tor_pkg::OP_CHAR_END, data: in_tdata, aux: count_inc};
        chr_count = 8'd0;
      end else begin
        chr_count = count_inc;
      end
    end else if (count_r != 8'd0) begin
      chr_push  = 1'b1;
      chr_cmd   = '{op: tor_pkg::OP_END, data: 8'd0, aux: count_r};
      chr_count = 8'd0;
    end
  end

  always_comb begin
    ps_nxt    = tor_pkg::PS_NORMAL;
    count_nxt = count_r;
    case (ps_r)
      tor_pkg::PS_IAC: begin
        case (in_tdata)
          tor_pkg::BYTE_IAC: begin
            count_nxt = chr_count;
          end
          tor_pkg::BYTE_WILL: ps_nxt = tor_pkg::PS_WILL;
          tor_pkg::BYTE_WONT: ps_nxt = tor_pkg::PS_WONT;
          tor_pkg::BYTE_DO:   ps_nxt = tor_pkg::PS_DO;
          tor_pkg::BYTE_DONT: ps_nxt = tor_pkg::PS_DONT;
          default:            ps_nxt = tor_pkg::PS_NORMAL;
        endcase
      end
      tor_pkg::PS_WILL, tor_pkg::PS_WONT, tor_pkg::PS_DO, tor_pkg::PS_DONT: begin
        ps_nxt = tor_pkg::PS_NORMAL;
      end
      default: begin
        if (in_tdata == tor_pkg::BYTE_IAC) begin
          ps_nxt = tor_pkg::PS_IAC;
        end else begin
          count_nxt = chr_count;
        end
      end
    endcase
  end

  always_comb begin
    push_c = 1'b0;
    cmd_c  = chr_cmd;
    case (ps_r)
      tor_pkg::PS_IAC: begin
        push_c = (in_tdata == tor_pkg::BYTE_IAC) && chr_push;
      end
      tor_pkg::PS_WILL, tor_pkg::PS_WONT: begin
        push_c = 1'b1;
        cmd_c  = '{op: tor_pkg::OP_REPLY, data: in_tdata, aux: tor_pkg::BYTE_DONT};
      end
      tor_pkg::PS_DO, tor_pkg::PS_DONT: begin
        push_c = 1'b1;
        cmd_c  = '{op: tor_pkg::OP_REPLY, data: in_tdata, aux: tor_pkg::BYTE_WONT};
      end
      default: begin
        push_c = (in_tdata != tor_pkg::BYTE_IAC) && chr_push;
      end
    endcase
  end

  assign q_push = in_xfer && push_c;
  assign q_cmd  = cmd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r       <= tor_pkg::PS_NORMAL;
      count_r    <= 8'd0;
      max_line_r <= tor_pkg::MAX_LINE_RESET;
    end else begin
      if (in_xfer) begin
        ps_r    <= ps_nxt;
        count_r <= count_nxt;
      end
      if (cfg_wr_en) begin
        max_line_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ sv/tor_queue.sv @@
// Short first-word-fall-through command queue between front and back end.
// Depends on tor_pkg for the command type.
module tor_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tor_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tor_pkg::cmd_t head_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  tor_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

@@ sv/tor_back.sv @@
// Back end: expands queued commands into result transfers through an output register.
// Depends on tor_pkg.
module tor_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  tor_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,   // out_byte[7:0], line_length[15:8]
  output logic [1:0]    out_tuser,   // out_kind[1:0]
  output logic          out_tlast
);

  logic [1:0]      step_r;
  logic            out_valid_r;
  logic [7:0]      byte_r, len_r;
  tor_pkg::kind_t  kind_r;
  logic            last_r;

  tor_pkg::kind_t  res_kind;
  logic [7:0]      res_byte, res_len;
  logic            res_last;
  logic            load;

  assign load    = cmd_valid && (!out_valid_r || out_tready);
  assign cmd_pop = load && res_last;

  always_comb begin
    res_kind = tor_pkg::KIND_CHAR;
    res_byte = cmd.data;
    res_len  = 8'd0;
    res_last = 1'b1;
    case (cmd.op)
      tor_pkg::OP_CHAR: begin
        res_last = 1'b1;
      end
      tor_pkg::OP_CHAR_END: begin
        if (step_r == 2'd0) begin
          res_last = 1'b0;
        end else begin
          res_kind = tor_pkg::KIND_END;
          res_byte = 8'd0;
          res_len  = cmd.aux;
        end
      end
      tor_pkg::OP_END: begin
        res_kind = tor_pkg::KIND_END;
        res_byte = 8'd0;
        res_len  = cmd.aux;
      end
      tor_pkg::OP_REPLY: begin
        res_kind = tor_pkg::KIND_REPLY;
        res_last = (step_r == 2'd3);
        case (step_r)
          2'd0:    res_byte = tor_pkg::BYTE_IAC;
          2'd1:    res_byte = cmd.aux;
          2'd2:    res_byte = cmd.data;
          default: res_byte = 8'd0;
        endcase
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        step_r      <= res_last ? 2'd0 : step_r + 2'd1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      len_r  <= res_len;
      last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {len_r, byte_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

@@ sim/tb.sv @@
// Testbench for telnet_option_refuser_line_parser: random and directed telnet bytes,
// checked result by result against a scoreboard that predicts replies and line output.
// Depends on tor_pkg and the parser RTL; needs nothing else.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tor_pkg::kind_t kind;
    logic [7:0]     data;
    logic [7:0]     len;
    logic           last;
  } parser_result_t;

  class line_parser_scoreboard;
    tor_pkg::ps_t   parse_st;
    logic [7:0]     line_cnt;
    logic [7:0]     max_len;
    parser_result_t expected_q[$];
    int             errors;

    function new();
      parse_st = tor_pkg::PS_NORMAL;
      line_cnt = 8'd0;
      max_len  = tor_pkg::MAX_LINE_RESET;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_max_len(logic [7:0] v);
      max_len = v;
    endfunction

    function void push_result(tor_pkg::kind_t k, logic [7:0] d, logic [7:0] l);
      parser_result_t r;
      r.kind = k;
      r.data = d;
      r.len  = l;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void line_char(logic [7:0] c);
      logic [7:0] limit;
      limit = (max_len == 8'd0) ? tor_pkg::MAX_LINE_ZERO : max_len;
      if (c == tor_pkg::BYTE_NUL) return;
      if (c != tor_pkg::BYTE_LF && c != tor_pkg::BYTE_CR) begin
        push_result(tor_pkg::KIND_CHAR, c, 8'd0);
        line_cnt = line_cnt + 8'd1;
        if (line_cnt >= limit) begin
          push_result(tor_pkg::KIND_END, 8'd0, line_cnt);
          line_cnt = 8'd0;
        end
      end else if (line_cnt != 8'd0) begin
        push_result(tor_pkg::KIND_END, 8'd0, line_cnt);
        line_cnt = 8'd0;
      end
    endfunction

    function void refuse(logic [7:0] verb, logic [7:0] opt);
      push_result(tor_pkg::KIND_REPLY, tor_pkg::BYTE_IAC, 8'd0);
      push_result(tor_pkg::KIND_REPLY, verb, 8'd0);
      push_result(tor_pkg::KIND_REPLY, opt, 8'd0);
      push_result(tor_pkg::KIND_REPLY, 8'd0, 8'd0);
    endfunction

    function void note_byte(logic [7:0] c);
      int n_prev;
      n_prev = expected_q.size();
      case (parse_st)
        tor_pkg::PS_IAC: begin
          parse_st = tor_pkg::PS_NORMAL;
          if (c == tor_pkg::BYTE_IAC) line_char(c);
          else if (c == tor_pkg::BYTE_WILL) parse_st = tor_pkg::PS_WILL;
          else if (c == tor_pkg::BYTE_WONT) parse_st = tor_pkg::PS_WONT;
          else if (c == tor_pkg::BYTE_DO) parse_st = tor_pkg::PS_DO;
          else if (c == tor_pkg::BYTE_DONT) parse_st = tor_pkg::PS_DONT;
        end
        tor_pkg::PS_WILL, tor_pkg::PS_WONT: begin
          refuse(tor_pkg::BYTE_DONT, c);
          parse_st = tor_pkg::PS_NORMAL;
        end
        tor_pkg::PS_DO, tor_pkg::PS_DONT: begin
          refuse(tor_pkg::BYTE_WONT, c);
          parse_st = tor_pkg::PS_NORMAL;
        end
        default: begin
          parse_st = tor_pkg::PS_NORMAL;
          if (c == tor_pkg::BYTE_IAC) parse_st = tor_pkg::PS_IAC;
          else line_char(c);
        end
      endcase
      if (expected_q.size() > n_prev) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic [7:0] len, logic last);
      parser_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h len %0d", kind, data, len));
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind %0d, expected %0d", kind, e.kind));
      if (data !== e.data)
        report($sformatf("byte %02h, expected %02h", data, e.data));
      if (len !== e.len)
        report($sformatf("line length %0d, expected %0d", len, e.len));
      if (last !== e.last)
        report($sformatf("last %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  logic [7:0]  stim_q[$];

  line_parser_scoreboard sb = new();

  telnet_option_refuser_line_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[7:0], out_tdata[15:8], out_tlast);
    end
  end

  // hold off the receiver for a long stretch on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 200;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task drive_queue();
    logic [7:0] b;
    while (stim_q.size() != 0) begin
      b = stim_q.pop_front();
      send_byte(b);
    end
    in_tvalid <= 1'b0;
  endtask

  task wait_drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_max_len(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    sb.set_max_len(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task fill_random(input int n);
    int r;
    int k;
    int run;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        run = $urandom_range(1, 12);
        repeat (run) stim_q.push_back(8'($urandom_range(1, 254)));
        k += run;
      end else if (r < 60) begin
        stim_q.push_back(($urandom_range(0, 1) != 0) ? tor_pkg::BYTE_CR : tor_pkg::BYTE_LF);
        k += 1;
      end else if (r < 82) begin
        stim_q.push_back(tor_pkg::BYTE_IAC);
        stim_q.push_back(8'($urandom_range(tor_pkg::BYTE_WILL, tor_pkg::BYTE_DONT)));
        stim_q.push_back(8'($urandom_range(0, 255)));
        k += 3;
      end else if (r < 88) begin
        stim_q.push_back(tor_pkg::BYTE_IAC);
        stim_q.push_back(tor_pkg::BYTE_IAC);
        k += 2;
      end else if (r < 93) begin
        stim_q.push_back(tor_pkg::BYTE_IAC);
        stim_q.push_back(8'($urandom_range(0, 250)));
        k += 2;
      end else begin
        stim_q.push_back(8'($urandom_range(0, 255)));
        k += 1;
      end
    end
  endtask

  task run_phase(input int n, input int idle, input int stall, input bit hold,
                 input bit pause);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_request = 1'b1;
    fill_random(n / 2);
    drive_queue();
    if (pause) wait_drain();
    fill_random(n - n / 2);
    drive_queue();
    wait_drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    stim_q = '{8'h41, tor_pkg::BYTE_NUL, tor_pkg::BYTE_CR, tor_pkg::BYTE_LF, 8'h7f, 8'h80,
               tor_pkg::BYTE_WILL, tor_pkg::BYTE_DONT,
               8'h01, tor_pkg::BYTE_IAC, tor_pkg::BYTE_IAC, tor_pkg::BYTE_LF,
               tor_pkg::BYTE_IAC, tor_pkg::BYTE_WILL, tor_pkg::BYTE_NUL,
               tor_pkg::BYTE_IAC, tor_pkg::BYTE_WONT, tor_pkg::BYTE_IAC,
               tor_pkg::BYTE_IAC, tor_pkg::BYTE_DO, 8'h18,
               tor_pkg::BYTE_IAC, tor_pkg::BYTE_DONT, 8'h01,
               tor_pkg::BYTE_IAC, 8'hf0, tor_pkg::BYTE_IAC, tor_pkg::BYTE_NUL, 8'h7a,
               tor_pkg::BYTE_CR};
    drive_queue();

    // lower the maximum below the running count
    repeat (6) stim_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    drive_queue();
    wait_drain();
    write_max_len(8'd3);
    stim_q = '{8'h71, tor_pkg::BYTE_LF};
    drive_queue();
    wait_drain();

    // zero maximum: no early line end
    write_max_len(8'd0);
    repeat (20) stim_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    stim_q.push_back(tor_pkg::BYTE_CR);
    drive_queue();
    wait_drain();

    write_max_len(8'd1);
    run_phase(25, 0, 0, 1'b0, 1'b0);
    write_max_len(8'd255);
    run_phase(25, 50, 0, 1'b0, 1'b0);
    write_max_len(8'd7);
    run_phase(25, 0, 50, 1'b1, 1'b0);
    write_max_len(8'($urandom_range(2, 30)));
    run_phase(25, 37, 37, 1'b0, 1'b1);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
